// ----- rtl/core/delta_list_timer_queue_top_defines.svh -----
// Assertion macros for the delta-list timer queue.
// No dependencies; taken in by the top level.
`ifndef DELTA_LIST_TIMER_QUEUE_TOP_DEFINES_SVH
`define DELTA_LIST_TIMER_QUEUE_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// checked outside reset only
`define DLTQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// checked at every edge, reset included
`define DLTQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define DLTQ_ASSERT(lbl, prop, msg)
`define DLTQ_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ----- rtl/core/dltq_pkg.sv -----
// Types, constants and helpers for the delta-list timer queue.
// No dependencies.
package dltq_pkg;

  localparam int NUM_TIMERS = 16;
  localparam int TICK_MS    = 10;
  localparam int MS_W       = 32;
  localparam int TMR_W      = 4;
  localparam int FLAG_CODES = 16;
  localparam int CNT_W      = $clog2(NUM_TIMERS + 1);
  localparam int OUT_CNT_W  = 5;

  // ms to ticks: floor(ms / TICK_MS) == (ms * DIV_MUL) >> (MS_W + DIV_SH) for every ms
  localparam int          DIV_SH  = $clog2(TICK_MS);
  localparam logic [63:0] DIV_MUL = ((64'd1 << (MS_W + DIV_SH)) + 64'(TICK_MS - 1))
                                    / 64'(TICK_MS);

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_SET    = 2'd1,
    OP_CHECK  = 2'd2,
    OP_CANCEL = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_e;

  typedef struct packed {
    op_e              op;
    logic [TMR_W-1:0] timer_index;
    logic [MS_W-1:0]  duration_ms;
  } cmd_t;

  typedef struct packed {
    logic                 flag_value;
    status_e              status;
    logic [OUT_CNT_W-1:0] fired_count;
    logic [OUT_CNT_W-1:0] active_count;
  } res_t;

  typedef struct packed {
    logic [TMR_W-1:0] tmr;
    logic [MS_W-1:0]  delta;
  } entry_t;

  typedef struct packed {
    logic shift;
    logic we;
  } cell_ctrl_t;

  function automatic logic [OUT_CNT_W-1:0] cnt_out(input logic [CNT_W-1:0] c);
    logic [CNT_W+OUT_CNT_W-1:0] e;
    e = {{OUT_CNT_W{1'b0}}, c};
    return e[OUT_CNT_W-1:0];
  endfunction

endpackage

// ----- rtl/core/dltq_cell.sv -----
// One list position of the queue: holds an entry, takes its right neighbor on shift.
// Depends on dltq_pkg.
module dltq_cell import dltq_pkg::*; (
  input  logic       clk_i,
  input  cell_ctrl_t ctrl_i,
  input  entry_t     wdata_i,
  input  entry_t     nxt_i,
  output entry_t     q_o
);

  entry_t entry_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.we) begin
      entry_q <= wdata_i;
    end else if (ctrl_i.shift) begin
      entry_q <= nxt_i;
    end
  end

  assign q_o = entry_q;

endmodule

// ----- rtl/core/dltq_div.sv -----
// Milliseconds to ticks by reciprocal multiply, result in the cycle after start.
// Depends on dltq_pkg.
module dltq_div import dltq_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [MS_W-1:0] dividend_i,
  output logic            done_o,
  output logic [MS_W-1:0] quot_o
);

  localparam int PROD_W = 2 * MS_W + 1;
  localparam logic [MS_W:0] MUL_C = DIV_MUL[MS_W:0];

  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] shifted;
  logic [MS_W-1:0]   quot_q;
  logic              done_q;

  assign prod    = {{(MS_W+1){1'b0}}, dividend_i} * {{MS_W{1'b0}}, MUL_C};
  assign shifted = prod >> (MS_W + DIV_SH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= shifted[MS_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// ----- rtl/core/delta_list_timer_queue_top.sv -----
// Delta-list timer queue: a chain of cells holds the list in expiry order.
// Per item: check answers at once; tick updates the head, then rotates or fires;
// cancel makes one pass; set does the tick conversion, then one rotation of the chain.
// One item at a time; the next is taken in the cycle its result strobes; no stall.
// Async active-low reset empties the list and clears all expire flags.
`include "delta_list_timer_queue_top_defines.svh"
module delta_list_timer_queue_top import dltq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  cmd_t cmd_i,
  output logic result_valid_o,
  output res_t result_o
);

  typedef enum logic [6:0] {
    S_IDLE      = 7'b0000001,
    S_DIV       = 7'b0000010,
    S_SET       = 7'b0000100,
    S_TICK_HEAD = 7'b0001000,
    S_TICK_ROT  = 7'b0010000,
    S_TICK_FIRE = 7'b0100000,
    S_CANCEL    = 7'b1000000
  } state_e;

  state_e                state_q, state_d;
  logic [CNT_W-1:0]      len_q, len_d;
  logic [CNT_W-1:0]      k_q, k_d;
  logic [CNT_W-1:0]      m_q, m_d;
  logic [MS_W-1:0]       prefix_q, prefix_d;
  logic [MS_W-1:0]       ticks_q, ticks_d;
  logic [TMR_W-1:0]      tmr_q, tmr_d;
  logic                  hit_q, hit_d;
  logic                  pend_q, pend_d;
  logic [MS_W-1:0]       pend_val_q, pend_val_d;
  logic [OUT_CNT_W-1:0]  fired_q, fired_d;
  logic [FLAG_CODES-1:0] flags_q, flags_d;
  res_t                  res_q, res_d;
  logic                  res_valid_q;

  logic             fin, fin_flag;
  status_e          fin_status;
  logic             pop, push;
  entry_t           wdata;
  logic [CNT_W-1:0] widx;
  logic [MS_W-1:0]  total, dec;
  logic             div_start, div_done;
  logic [MS_W-1:0]  div_quot;
  logic             accept;

  entry_t     cell_q [NUM_TIMERS];
  cell_ctrl_t ctrl   [NUM_TIMERS];
  entry_t     head;

  assign head   = cell_q[0];
  assign accept = start && state_q == S_IDLE;
  assign widx   = pop ? len_q - CNT_W'(1) : len_q;

  for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_cell
    entry_t nxt;
    if (i == NUM_TIMERS - 1) begin : g_last
      assign nxt = cell_q[i];
    end else begin : g_mid
      assign nxt = cell_q[i+1];
    end
    assign ctrl[i] = '{shift: pop, we: push && (widx == CNT_W'(i))};
    dltq_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl[i]),
      .wdata_i (wdata),
      .nxt_i   (nxt),
      .q_o     (cell_q[i])
    );
  end

  dltq_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (cmd_i.duration_ms),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  always_comb begin
    state_d    = state_q;
    k_d        = k_q;
    m_d        = m_q;
    prefix_d   = prefix_q;
    ticks_d    = ticks_q;
    tmr_d      = tmr_q;
    hit_d      = hit_q;
    pend_d     = pend_q;
    pend_val_d = pend_val_q;
    fired_d    = fired_q;
    flags_d    = flags_q;
    fin        = 1'b0;
    fin_flag   = 1'b0;
    fin_status = ST_OK;
    pop        = 1'b0;
    push       = 1'b0;
    wdata      = head;
    div_start  = 1'b0;
    total      = prefix_q + head.delta;
    dec        = (head.delta == '0) ? '0 : head.delta - MS_W'(1);

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          tmr_d  = cmd_i.timer_index;
          k_d    = '0;
          m_d    = len_q;
          hit_d  = 1'b0;
          pend_d = 1'b0;
          case (cmd_i.op)
            OP_TICK: begin
              fired_d = '0;
              if (len_q == '0) begin
                fin = 1'b1;
              end else begin
                state_d = S_TICK_HEAD;
              end
            end
            OP_SET: begin
              if (len_q == CNT_W'(NUM_TIMERS)) begin
                fin        = 1'b1;
                fin_status = ST_FULL;
              end else begin
                div_start = 1'b1;
                state_d   = S_DIV;
              end
            end
            OP_CHECK: begin
              fin      = 1'b1;
              fin_flag = flags_q[cmd_i.timer_index];
              flags_d[cmd_i.timer_index] = 1'b0;
            end
            OP_CANCEL: begin
              flags_d[cmd_i.timer_index] = 1'b0;
              state_d = S_CANCEL;
            end
            default: ;
          endcase
        end
      end
      S_DIV: begin
        if (div_done) begin
          ticks_d  = div_quot;
          prefix_d = '0;
          state_d  = S_SET;
        end
      end
      S_SET: begin
        if (k_q < m_q) begin
          if (!hit_q && ticks_q < total) begin
            // new entry goes ahead of the head; head keeps the remainder
            push       = 1'b1;
            wdata.tmr  = tmr_q;
            wdata.delta = ticks_q - prefix_q;
            hit_d      = 1'b1;
            pend_d     = 1'b1;
            pend_val_d = total - ticks_q;
          end else begin
            pop  = 1'b1;
            push = 1'b1;
            if (pend_q) begin
              wdata.delta = pend_val_q;
              pend_d      = 1'b0;
            end
            if (!hit_q) begin
              prefix_d = total;
            end
            k_d = k_q + CNT_W'(1);
          end
        end else if (!hit_q) begin
          push        = 1'b1;
          wdata.tmr   = tmr_q;
          wdata.delta = ticks_q - prefix_q;
          hit_d       = 1'b1;
        end else begin
          fin = 1'b1;
        end
      end
      S_TICK_HEAD: begin
        pop = 1'b1;
        if (dec == '0) begin
          flags_d[head.tmr] = 1'b1;
          fired_d = OUT_CNT_W'(1);
          state_d = S_TICK_FIRE;
        end else begin
          push        = 1'b1;
          wdata.delta = dec;
          k_d         = CNT_W'(1);
          state_d     = S_TICK_ROT;
        end
      end
      S_TICK_ROT: begin
        if (k_q < m_q) begin
          pop  = 1'b1;
          push = 1'b1;
          k_d  = k_q + CNT_W'(1);
        end else begin
          fin = 1'b1;
        end
      end
      S_TICK_FIRE: begin
        if (len_q != '0 && head.delta == '0) begin
          pop = 1'b1;
          flags_d[head.tmr] = 1'b1;
          fired_d = fired_q + OUT_CNT_W'(1);
        end else begin
          fin = 1'b1;
        end
      end
      S_CANCEL: begin
        if (k_q < m_q) begin
          pop = 1'b1;
          k_d = k_q + CNT_W'(1);
          if (!hit_q && head.tmr == tmr_q) begin
            // drop it, fold its delta into the next entry
            hit_d      = 1'b1;
            pend_d     = 1'b1;
            pend_val_d = head.delta;
          end else begin
            push = 1'b1;
            if (pend_q) begin
              wdata.delta = head.delta + pend_val_q;
              pend_d      = 1'b0;
            end
          end
        end else begin
          fin        = 1'b1;
          fin_status = hit_q ? ST_OK : ST_NOT_FOUND;
        end
      end
      default: state_d = S_IDLE;
    endcase

    case ({push, pop})
      2'b10:   len_d = len_q + CNT_W'(1);
      2'b01:   len_d = len_q - CNT_W'(1);
      default: len_d = len_q;
    endcase

    res_d = res_q;
    if (fin) begin
      state_d            = S_IDLE;
      res_d.flag_value   = fin_flag;
      res_d.status       = fin_status;
      res_d.fired_count  = (state_q == S_TICK_FIRE) ? fired_q : '0;
      res_d.active_count = cnt_out(len_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      len_q       <= '0;
      k_q         <= '0;
      m_q         <= '0;
      hit_q       <= 1'b0;
      pend_q      <= 1'b0;
      fired_q     <= '0;
      flags_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      k_q         <= k_d;
      m_q         <= m_d;
      hit_q       <= hit_d;
      pend_q      <= pend_d;
      fired_q     <= fired_d;
      flags_q     <= flags_d;
      res_valid_q <= fin;
    end
  end

  always_ff @(posedge clk_i) begin
    prefix_q   <= prefix_d;
    ticks_q    <= ticks_d;
    tmr_q      <= tmr_d;
    pend_val_q <= pend_val_d;
    res_q      <= res_d;
  end

  assign busy           = state_q != S_IDLE;
  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

  `DLTQ_ASSERT(a_len_bound, len_q <= CNT_W'(NUM_TIMERS), "list length past capacity")
  `DLTQ_ASSERT_ALWAYS(a_result_idle, result_valid_o |-> !busy, "result while still busy")
  `DLTQ_ASSERT(a_check_one_cycle, accept && cmd_i.op == OP_CHECK |=> result_valid_o && !busy,
               "check item gave no result next cycle")

endmodule

// ----- bench/dltq_checker.sv -----
// Checker for the delta-list timer queue: watches accepted items and result strobes,
// keeps its own timer list and compares each result as a whole.
// Depends on dltq_pkg.
module dltq_checker import dltq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  input  logic busy,
  input  cmd_t cmd_i,
  input  logic result_valid_o,
  input  res_t result_o,
  output int   fail_count,
  output int   pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [TMR_W-1:0] q_tmr[$];
  logic [31:0]      q_delta[$];
  logic             flags[FLAG_CODES];
  res_t             expected_q[$];

  function automatic res_t predict(cmd_t c);
    res_t r;
    logic [31:0] ticks, prefix, total;
    int pos, fired;
    r = '0;
    r.status = ST_OK;
    case (c.op)
      OP_TICK: begin
        fired = 0;
        if (q_tmr.size() > 0) begin
          if (q_delta[0] != 0) q_delta[0] = q_delta[0] - 1;
          while (q_tmr.size() > 0 && q_delta[0] == 0) begin
            flags[q_tmr[0]] = 1'b1;
            void'(q_tmr.pop_front());
            void'(q_delta.pop_front());
            fired++;
          end
        end
        r.fired_count = fired[4:0];
      end
      OP_SET: begin
        if (q_tmr.size() >= NUM_TIMERS) begin
          r.status = ST_FULL;
        end else begin
          ticks = c.duration_ms / TICK_MS;
          prefix = 0;
          for (pos = 0; pos < q_tmr.size(); pos++) begin
            total = prefix + q_delta[pos];
            if (ticks < total) begin
              q_delta[pos] = total - ticks;
              break;
            end
            prefix = total;
          end
          q_tmr.insert(pos, c.timer_index);
          q_delta.insert(pos, ticks - prefix);
        end
      end
      OP_CHECK: begin
        r.flag_value = flags[c.timer_index];
        flags[c.timer_index] = 1'b0;
      end
      default: begin
        flags[c.timer_index] = 1'b0;
        for (pos = 0; pos < q_tmr.size(); pos++)
          if (q_tmr[pos] == c.timer_index) break;
        if (pos >= q_tmr.size()) begin
          r.status = ST_NOT_FOUND;
        end else begin
          if (pos + 1 < q_tmr.size()) q_delta[pos+1] = q_delta[pos+1] + q_delta[pos];
          q_tmr.delete(pos);
          q_delta.delete(pos);
        end
      end
    endcase
    r.active_count = 5'(q_tmr.size());
    return r;
  endfunction

  assign pending_count = expected_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    res_t e;
    if (!rst_ni) begin
      fail_count <= 0;
      expected_q.delete();
      q_tmr.delete();
      q_delta.delete();
      foreach (flags[i]) flags[i] = 1'b0;
    end else begin
      if (result_valid_o) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result %p", $time, result_o);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_q.pop_front();
          if (result_o !== e) begin
            $display("%0t: mismatch expected %p actual %p", $time, e, result_o);
            fail_count <= fail_count + 1;
          end
        end
      end
      // item accepted at this edge; its result cannot strobe at the same edge
      if (start && !busy) expected_q.push_back(predict(cmd_i));
    end
  end
endmodule

// ----- bench/tb_delta_list_timer_queue_top.sv -----
// Testbench top for the delta-list timer queue: clock, reset, stimulus, verdict.
// Depends on dltq_pkg, delta_list_timer_queue_top and dltq_checker.
module tb_delta_list_timer_queue_top;
  import dltq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  cmd_t cmd_i = '0;
  logic result_valid_o;
  res_t result_o;
  int   fail_count, pending_count;
  int   cycle_count = 0;
  bit   quiet = 1'b0;

  always #5 clk_i = ~clk_i;

  delta_list_timer_queue_top DUT (.*);
  dltq_checker u_checker (.*);

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 600000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // start stays high after the accept until the next item or an idle cycle replaces it
  task automatic send_item(op_e op, logic [3:0] tmr, logic [31:0] ms);
    while (!quiet && $urandom_range(99) < 8) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start <= 1'b1;
    cmd_i <= '{op: op, timer_index: tmr, duration_ms: ms};
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // mostly short timers so the list both fills and drains
  function automatic logic [31:0] pick_ms();
    case ($urandom_range(9))
      0: return $urandom();
      1: return 32'hFFFF_FFFF - $urandom_range(20);
      2: return $urandom_range(9);
      default: return $urandom_range(300);
    endcase
  endfunction

  initial begin
    int k, r;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    // directed: empty tick, zero-tick head, equal expiries, full list, extremes
    send_item(OP_TICK, 4'd0, 32'd0);
    send_item(OP_CANCEL, 4'd15, 32'd0);
    send_item(OP_SET, 4'd3, 32'd0);
    send_item(OP_SET, 4'd4, 32'd9);
    send_item(OP_TICK, 4'd0, 32'd0);
    send_item(OP_CHECK, 4'd3, 32'd0);
    send_item(OP_CHECK, 4'd4, 32'd0);
    send_item(OP_CHECK, 4'd4, 32'd0);
    for (k = 0; k < 17; k++)
      send_item(OP_SET, k[3:0], (k == 16) ? 32'hFFFF_FFFF : 32'd20 + 32'd10 * (k % 4));
    send_item(OP_CANCEL, 4'd1, 32'd0);
    send_item(OP_SET, 4'd1, 32'hFFFF_FFFF);
    send_item(OP_TICK, 4'hF, 32'hAAAA_5555);
    send_item(OP_TICK, 4'hF, 32'h5555_AAAA);
    for (k = 0; k < 16; k++) send_item(OP_CANCEL, k[3:0], 32'd0);
    // hold off until the queue has drained
    start <= 1'b0;
    @(negedge clk_i);
    while (pending_count != 0) @(negedge clk_i);
    for (k = 0; k < 1800; k++) begin
      quiet = (k >= 800 && k < 1000);
      r = $urandom_range(99);
      if (r < 40) send_item(OP_TICK, 4'($urandom()), $urandom());
      else if (r < 70) send_item(OP_SET, 4'($urandom()), pick_ms());
      else if (r < 85) send_item(OP_CHECK, 4'($urandom()), $urandom());
      else send_item(OP_CANCEL, 4'($urandom()), $urandom());
    end
    start <= 1'b0;
    @(negedge clk_i);
    while (pending_count != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
    if (fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule
